@@ src/wsp_pkg.sv @@
// Shared types and constants for the WAV stream parser.
package wsp_pkg;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
   localparam logic [2:0] ERR_NOT_WAV     = 3'd2;
   localparam logic [2:0] ERR_SHORT_FMT   = 3'd3;
   localparam logic [2:0] ERR_MALFORMED   = 3'd4;
   localparam logic [2:0] ERR_UNSUPPORTED = 3'd5;
   localparam logic [2:0] ERR_SHORT_DATA  = 3'd6;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] sample_bits;
      logic [15:0] channel_index;
      logic [30:0] frame_index;
      logic [15:0] channel_count;
      logic [31:0] rate_hz;
      logic [30:0] frame_count;
      logic        is_float;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic finish_div;
      logic load_pend;
   } cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       need_div;
      logic [1:0] byte_cnt;
      logic [1:0] fin_cnt;
      logic       div_busy;
   } status_type;

endpackage

@@ src/wsp_req_if.sv @@
// Input byte channel.
interface wsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

@@ src/wsp_rsp_if.sv @@
// Result channel.
interface wsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] sample_bits;
   logic [15:0] channel_index;
   logic [30:0] frame_index;
   logic [15:0] channel_count;
   logic [31:0] rate_hz;
   logic [30:0] frame_count;
   logic        is_float;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, output result_kind, output sample_bits,
                   output channel_index, output frame_index, output channel_count,
                   output rate_hz, output frame_count, output is_float,
                   output error_code, output last, input ready);
   modport sink (input valid, input result_kind, input sample_bits,
                 input channel_index, input frame_index, input channel_count,
                 input rate_hz, input frame_count, input is_float,
                 input error_code, input last, output ready);
endinterface

@@ src/wsp_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module wsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [15:0] remainder
);

   logic [5:0]  count_ff, count_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, quo_ff[31]};
      if (start) begin
         count_in = 6'd32;
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (count_ff != 6'd0) begin
         count_in = count_ff - 6'd1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = (count_ff != 6'd0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ src/wsp_dp.sv @@
// Parser datapath: parse state, sample conversion, frame-count divide, result slot.
module wsp_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_file,
   input  logic                rsp_ready,
   input  wsp_pkg::cmd_type    cmd,
   output wsp_pkg::status_type status,
   output logic                rsp_valid,
   output wsp_pkg::rsp_type    rsp_data
);

   typedef enum logic [2:0] {
      PH_HDR, PH_HDR_BAD, PH_CHUNK, PH_FMT, PH_SKIP, PH_DATA, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  bc_ff, bc_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] clen_ff, clen_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [15:0] chs_ff, chs_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        found_ff, found_in;
   logic [31:0] dleft_ff, dleft_in;
   logic [31:0] samp_ff, samp_in;
   logic [15:0] chc_ff, chc_in;
   logic [30:0] frc_ff, frc_in;

   wsp_pkg::rsp_type res_a, res_b, fin_a, fin_b, pend_ff, out_ff;
   logic        out_valid_ff;
   logic [1:0]  byte_cnt, fin_cnt;
   logic        need_div;
   logic        pcm_ok, flt_ok;
   logic [31:0] div_dividend, div_quo;
   logic [15:0] div_rem;
   logic        div_busy;
   logic [31:0] lq, clen_fin;
   logic [15:0] chc_p1;
   logic        out_free;

   function automatic logic [31:0] pcm_to_float(input logic [15:0] raw);
      logic [15:0] mag;
      logic [3:0]  e;
      logic [38:0] sh;
      logic [31:0] res;
      mag = raw[15] ? (16'h0000 - raw) : raw;
      e = '0;
      for (int i = 1; i < 16; i++) begin
         if (mag[i]) e = 4'(i);
      end
      sh = {23'b0, mag} << (5'd23 - {1'b0, e});
      if (mag == 16'h0000) res = '0;
      else res = {raw[15], 8'({4'b0, e} + 8'd112), sh[22:0]};
      return res;
   endfunction

   function automatic wsp_pkg::rsp_type mk_err(input logic [2:0] code);
      wsp_pkg::rsp_type r;
      r = '0;
      r.result_kind = wsp_pkg::KIND_ERROR;
      r.error_code  = code;
      return r;
   endfunction

   function automatic wsp_pkg::rsp_type mk_finish();
      wsp_pkg::rsp_type r;
      r = '0;
      r.result_kind = wsp_pkg::KIND_FINISH;
      return r;
   endfunction

   assign pcm_ok = (fmt_ff == 16'd1) && (bits_ff == 16'd16);
   assign flt_ok = (fmt_ff == 16'd3) && (bits_ff == 16'd32);
   assign chc_p1 = chc_ff + 16'd1;

   // byte or end-of-file beat
   always_comb begin
      phase_in = phase_ff; bc_in = bc_ff; tag_in = tag_ff; clen_in = clen_ff;
      fmt_in = fmt_ff; chs_in = chs_ff; rate_in = rate_ff; bits_in = bits_ff;
      found_in = found_ff; dleft_in = dleft_ff; samp_in = samp_ff;
      chc_in = chc_ff; frc_in = frc_ff;
      res_a = '0; res_b = '0; byte_cnt = 2'd0; need_div = 1'b0;
      if (req_end_of_file) begin
         byte_cnt = 2'd1;
         case (phase_ff)
            PH_HDR, PH_HDR_BAD: res_a = mk_err(wsp_pkg::ERR_SHORT_HDR);
            PH_FMT:             res_a = mk_err(wsp_pkg::ERR_SHORT_FMT);
            PH_CHUNK, PH_SKIP:  res_a = mk_err(wsp_pkg::ERR_MALFORMED);
            PH_DATA:            res_a = mk_err(wsp_pkg::ERR_SHORT_DATA);
            default:            byte_cnt = 2'd0;
         endcase
         phase_in = PH_HDR; bc_in = '0; tag_in = '0; clen_in = '0;
         fmt_in = '0; chs_in = '0; rate_in = '0; bits_in = '0;
         found_in = 1'b0; dleft_in = '0; samp_in = '0; chc_in = '0; frc_in = '0;
      end else begin
         case (phase_ff)
            PH_HDR, PH_HDR_BAD: begin
               tag_in = {tag_ff[23:0], req_data_byte};
               bc_in  = bc_ff + 5'd1;
               if (bc_in == 5'd4 && tag_in != wsp_pkg::TAG_RIFF) phase_in = PH_HDR_BAD;
               if (bc_in == 5'd12) begin
                  bc_in = '0;
                  if (phase_in == PH_HDR_BAD || tag_in != wsp_pkg::TAG_WAVE) begin
                     res_a = mk_err(wsp_pkg::ERR_NOT_WAV);
                     byte_cnt = 2'd1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_CHUNK;
                  end
               end
            end
            PH_CHUNK: begin
               if (bc_ff < 5'd4) tag_in = {tag_ff[23:0], req_data_byte};
               else clen_in = {req_data_byte, clen_ff[31:8]};
               bc_in = bc_ff + 5'd1;
               if (bc_in == 5'd8) begin
                  bc_in = '0;
                  if (tag_in == wsp_pkg::TAG_FMT) begin
                     phase_in = PH_FMT;
                  end else if (tag_in == wsp_pkg::TAG_DATA) begin
                     if (!found_ff) begin
                        res_a = mk_err(wsp_pkg::ERR_MALFORMED);
                        byte_cnt = 2'd1;
                        phase_in = PH_DONE;
                     end else if ((!pcm_ok && !flt_ok) || chs_ff == 16'd0) begin
                        res_a = mk_err(wsp_pkg::ERR_UNSUPPORTED);
                        byte_cnt = 2'd1;
                        phase_in = PH_DONE;
                     end else begin
                        need_div = 1'b1;
                     end
                  end else if (clen_in != 32'd0) begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               if (bc_ff < 5'd2) fmt_in = {req_data_byte, fmt_ff[15:8]};
               else if (bc_ff < 5'd4) chs_in = {req_data_byte, chs_ff[15:8]};
               else if (bc_ff < 5'd8) rate_in = {req_data_byte, rate_ff[31:8]};
               else if (bc_ff >= 5'd14) bits_in = {req_data_byte, bits_ff[15:8]};
               bc_in = bc_ff + 5'd1;
               if (bc_in == 5'd16) begin
                  bc_in = '0;
                  found_in = 1'b1;
                  if (clen_ff > 32'd16) begin
                     clen_in  = clen_ff - 32'd16;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_CHUNK;
                  end
               end
            end
            PH_SKIP: begin
               if (clen_ff != 32'd0) clen_in = clen_ff - 32'd1;
               if (clen_in == 32'd0) begin
                  bc_in = '0;
                  phase_in = PH_CHUNK;
               end
            end
            PH_DATA: begin
               if (clen_ff != 32'd0) begin
                  clen_in = clen_ff - 32'd1;
                  samp_in = {req_data_byte, samp_ff[31:8]};
                  bc_in   = bc_ff + 5'd1;
                  if (bc_in == ((bits_ff == 16'd16) ? 5'd2 : 5'd4)) begin
                     bc_in = '0;
                     res_a.result_kind   = wsp_pkg::KIND_SAMPLE;
                     res_a.sample_bits   = (bits_ff == 16'd16) ?
                                           pcm_to_float(samp_in[31:16]) : samp_in;
                     res_a.channel_index = chc_ff;
                     res_a.frame_index   = frc_ff;
                     byte_cnt = 2'd1;
                     if (chc_p1 >= chs_ff) begin
                        chc_in = '0;
                        frc_in = frc_ff + 31'd1;
                     end else begin
                        chc_in = chc_p1;
                     end
                  end
               end
               if (dleft_ff != 32'd0) dleft_in = dleft_ff - 32'd1;
               if (dleft_in == 32'd0) begin
                  phase_in = PH_DONE;
                  if (byte_cnt == 2'd1) begin
                     res_b = mk_finish();
                     byte_cnt = 2'd2;
                  end else begin
                     res_a = mk_finish();
                     byte_cnt = 2'd1;
                  end
               end
            end
            default: ;
         endcase
      end
      res_a.last = (byte_cnt == 2'd1);
      res_b.last = 1'b1;
   end

   // frame count from the data chunk size
   assign div_dividend = (fmt_ff == 16'd1) ? {1'b0, clen_in[31:1]} : {2'b0, clen_in[31:2]};

   wsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (chs_ff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      lq = (fmt_ff == 16'd1) ? {1'b0, clen_ff[31:1]} : {2'b0, clen_ff[31:2]};
      clen_fin = (fmt_ff == 16'd1) ? ((lq - {16'b0, div_rem}) << 1)
                                   : ((lq - {16'b0, div_rem}) << 2);
      fin_cnt = (clen_ff == 32'd0) ? 2'd2 : 2'd1;
      fin_a = '0;
      fin_a.result_kind   = wsp_pkg::KIND_FORMAT;
      fin_a.channel_count = chs_ff;
      fin_a.rate_hz       = rate_ff;
      fin_a.frame_count   = div_quo[30:0];
      fin_a.is_float      = flt_ok;
      fin_a.last          = (fin_cnt == 2'd1);
      fin_b      = mk_finish();
      fin_b.last = 1'b1;
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR; bc_ff <= '0; tag_ff <= '0; clen_ff <= '0;
         fmt_ff <= '0; chs_ff <= '0; rate_ff <= '0; bits_ff <= '0;
         found_ff <= 1'b0; dleft_ff <= '0; samp_ff <= '0; chc_ff <= '0; frc_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            phase_ff <= phase_in; bc_ff <= bc_in; tag_ff <= tag_in; clen_ff <= clen_in;
            fmt_ff <= fmt_in; chs_ff <= chs_in; rate_ff <= rate_in; bits_ff <= bits_in;
            found_ff <= found_in; dleft_ff <= dleft_in; samp_ff <= samp_in;
            chc_ff <= chc_in; frc_ff <= frc_in;
         end else if (cmd.finish_div) begin
            dleft_ff <= clen_ff;
            clen_ff  <= clen_fin;
            bc_ff <= '0; samp_ff <= '0; chc_ff <= '0; frc_ff <= '0;
            phase_ff <= (clen_ff == 32'd0) ? PH_DONE : PH_DATA;
         end
         if ((cmd.accept && byte_cnt != 2'd0) || cmd.finish_div || cmd.load_pend) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (cmd.load_pend) begin
         out_ff <= pend_ff;
      end else if (cmd.accept && byte_cnt != 2'd0) begin
         out_ff  <= res_a;
         pend_ff <= res_b;
      end else if (cmd.finish_div) begin
         out_ff  <= fin_a;
         pend_ff <= fin_b;
      end
   end

   assign status.out_free = out_free;
   assign status.need_div = need_div;
   assign status.byte_cnt = byte_cnt;
   assign status.fin_cnt  = fin_cnt;
   assign status.div_busy = div_busy;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

@@ src/wsp_ctrl.sv @@
// Sequencer: byte acceptance, frame-count divide wait, second result beat.
module wsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  wsp_pkg::status_type status,
   output logic                req_ready,
   output wsp_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {S_RUN, S_DIV, S_HOLD} state_type;

   state_type state_ff;

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == S_RUN) && status.out_free;
      case (state_ff)
         S_RUN: begin
            cmd.accept    = req_valid && req_ready;
            cmd.div_start = cmd.accept && status.need_div;
         end
         S_DIV:  cmd.finish_div = !status.div_busy && status.out_free;
         S_HOLD: cmd.load_pend  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         case (state_ff)
            S_RUN: begin
               if (cmd.div_start) state_ff <= S_DIV;
               else if (cmd.accept && status.byte_cnt == 2'd2) state_ff <= S_HOLD;
            end
            S_DIV: begin
               if (cmd.finish_div) state_ff <= (status.fin_cnt == 2'd2) ? S_HOLD : S_RUN;
            end
            S_HOLD: begin
               if (cmd.load_pend) state_ff <= S_RUN;
            end
            default: state_ff <= S_RUN;
         endcase
      end
   end

endmodule

@@ src/wav_stream_parser.sv @@
// WAV stream parser top level.
// Takes a WAV file one byte per beat, checks the RIFF/WAVE header, walks the
// chunks and, at the data chunk, emits a format beat followed by one beat per
// sample (IEEE single bits, interleaved order) and a final status beat. Samples
// are provisional until that status arrives. A byte is taken every cycle while
// the result slot is free; a byte that yields two results holds off input
// until the second beat is in the slot. The data chunk header stalls input
// until a 32-step divider has the frame count, longer while the slot is held.
module wav_stream_parser (
   input  logic clock,
   input  logic reset,
   wsp_req_if.sink   req_bus,
   wsp_rsp_if.source rsp_bus
);

   wsp_pkg::cmd_type    cmd;
   wsp_pkg::status_type status;
   wsp_pkg::rsp_type    rsp_data;

   wsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   wsp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_bus.data_byte),
      .req_end_of_file (req_bus.end_of_file),
      .rsp_ready       (rsp_bus.ready),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_data        (rsp_data)
   );

   assign rsp_bus.result_kind   = rsp_data.result_kind;
   assign rsp_bus.sample_bits   = rsp_data.sample_bits;
   assign rsp_bus.channel_index = rsp_data.channel_index;
   assign rsp_bus.frame_index   = rsp_data.frame_index;
   assign rsp_bus.channel_count = rsp_data.channel_count;
   assign rsp_bus.rate_hz       = rsp_data.rate_hz;
   assign rsp_bus.frame_count   = rsp_data.frame_count;
   assign rsp_bus.is_float      = rsp_data.is_float;
   assign rsp_bus.error_code    = rsp_data.error_code;
   assign rsp_bus.last          = rsp_data.last;

endmodule

@@ sim/wsp_check.sv @@
// Checker for the WAV stream parser: predicts results from accepted byte beats and compares.
`timescale 1ns / 1ps
module wsp_check (
   input  logic clock,
   input  logic reset,
   wsp_req_if.sink   req_mon,
   wsp_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending_count
);

   typedef enum logic [2:0] {
      PH_HDR, PH_HDR_BAD, PH_CHUNK, PH_FMT, PH_SKIP, PH_DATA, PH_DONE
   } phase_type;

   phase_type   phase;
   logic [31:0] byte_cnt, tag_sr, chunk_len, rate_v, data_left, samp_sr;
   logic [15:0] fmt_code, chan_v, bits_v, chan_ctr;
   logic        fmt_found;
   logic [30:0] frame_ctr;
   wsp_pkg::rsp_type rsp_queue[$];
   wsp_pkg::rsp_type got;
   int          n_in_step;

   assign pending_count = rsp_queue.size();

   function automatic logic [31:0] pcm_to_float(logic [15:0] raw);
      logic        sgn;
      logic [16:0] mag;
      int          e;
      sgn = raw[15];
      mag = sgn ? (17'h10000 - raw) : {1'b0, raw};
      if (mag == 0) return 32'd0;
      e = 0;
      while (e < 15 && (mag >> (e + 1)) != 0) e++;
      return {sgn, 8'(e + 112), 23'((32'(mag) << (23 - e)) & 32'h7FFFFF)};
   endfunction

   function automatic wsp_pkg::rsp_type make_rsp(logic [1:0] kind, logic [2:0] err);
      wsp_pkg::rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.error_code = err;
      return r;
   endfunction

   task automatic push_rsp(wsp_pkg::rsp_type r);
      rsp_queue.push_back(r);
      n_in_step++;
   endtask

   task automatic push_error(logic [2:0] err);
      phase = PH_DONE;
      push_rsp(make_rsp(wsp_pkg::KIND_ERROR, err));
   endtask

   task automatic clear_state();
      phase = PH_HDR;
      byte_cnt = 0; tag_sr = 0; chunk_len = 0; fmt_code = 0; chan_v = 0;
      rate_v = 0; bits_v = 0; fmt_found = 0; data_left = 0; samp_sr = 0;
      chan_ctr = 0; frame_ctr = 0;
   endtask

   task automatic open_data();
      logic        pcm, flt;
      logic [31:0] nbytes, fc;
      wsp_pkg::rsp_type r;
      pcm = (fmt_code == 1 && bits_v == 16);
      flt = (fmt_code == 3 && bits_v == 32);
      if (!fmt_found) begin
         push_error(wsp_pkg::ERR_MALFORMED);
         return;
      end
      if ((!pcm && !flt) || chan_v == 0) begin
         push_error(wsp_pkg::ERR_UNSUPPORTED);
         return;
      end
      nbytes = pcm ? 2 : 4;
      fc = chunk_len / nbytes / chan_v;
      data_left = chunk_len;
      chunk_len = 32'(64'(fc) * chan_v * nbytes);
      byte_cnt = 0; samp_sr = 0; chan_ctr = 0; frame_ctr = 0;
      r = make_rsp(wsp_pkg::KIND_FORMAT, '0);
      r.channel_count = chan_v;
      r.rate_hz = rate_v;
      r.frame_count = fc[30:0];
      r.is_float = flt;
      push_rsp(r);
      if (data_left == 0) begin
         phase = PH_DONE;
         push_rsp(make_rsp(wsp_pkg::KIND_FINISH, '0));
      end else begin
         phase = PH_DATA;
      end
   endtask

   task automatic predict_byte(logic [7:0] b, logic eof);
      logic [31:0] nbytes;
      wsp_pkg::rsp_type r;
      n_in_step = 0;
      if (eof) begin
         case (phase)
            PH_HDR, PH_HDR_BAD: push_error(wsp_pkg::ERR_SHORT_HDR);
            PH_FMT:             push_error(wsp_pkg::ERR_SHORT_FMT);
            PH_CHUNK, PH_SKIP:  push_error(wsp_pkg::ERR_MALFORMED);
            PH_DATA:            push_error(wsp_pkg::ERR_SHORT_DATA);
            default: ;
         endcase
         clear_state();
      end else begin
         case (phase)
            PH_HDR, PH_HDR_BAD: begin
               tag_sr = {tag_sr[23:0], b};
               byte_cnt++;
               if (byte_cnt == 4 && tag_sr != wsp_pkg::TAG_RIFF) phase = PH_HDR_BAD;
               if (byte_cnt >= 12) begin
                  byte_cnt = 0;
                  if (phase == PH_HDR_BAD || tag_sr != wsp_pkg::TAG_WAVE)
                     push_error(wsp_pkg::ERR_NOT_WAV);
                  else phase = PH_CHUNK;
               end
            end
            PH_CHUNK: begin
               if (byte_cnt < 4) tag_sr = {tag_sr[23:0], b};
               else chunk_len = {b, chunk_len[31:8]};
               byte_cnt++;
               if (byte_cnt >= 8) begin
                  byte_cnt = 0;
                  if (tag_sr == wsp_pkg::TAG_FMT) phase = PH_FMT;
                  else if (tag_sr == wsp_pkg::TAG_DATA) open_data();
                  else if (chunk_len != 0) phase = PH_SKIP;
               end
            end
            PH_FMT: begin
               if (byte_cnt < 2) fmt_code = {b, fmt_code[15:8]};
               else if (byte_cnt < 4) chan_v = {b, chan_v[15:8]};
               else if (byte_cnt < 8) rate_v = {b, rate_v[31:8]};
               else if (byte_cnt >= 14) bits_v = {b, bits_v[15:8]};
               byte_cnt++;
               if (byte_cnt >= 16) begin
                  byte_cnt = 0;
                  fmt_found = 1;
                  if (chunk_len > 16) begin
                     chunk_len -= 16;
                     phase = PH_SKIP;
                  end else begin
                     phase = PH_CHUNK;
                  end
               end
            end
            PH_SKIP: begin
               if (chunk_len != 0) chunk_len--;
               if (chunk_len == 0) begin
                  byte_cnt = 0;
                  phase = PH_CHUNK;
               end
            end
            PH_DATA: begin
               nbytes = (bits_v == 16) ? 2 : 4;
               if (chunk_len != 0) begin
                  chunk_len--;
                  samp_sr = {b, samp_sr[31:8]};
                  byte_cnt++;
                  if (byte_cnt >= nbytes) begin
                     byte_cnt = 0;
                     r = make_rsp(wsp_pkg::KIND_SAMPLE, '0);
                     r.sample_bits = (nbytes == 2) ? pcm_to_float(samp_sr[31:16]) : samp_sr;
                     r.channel_index = chan_ctr;
                     r.frame_index = frame_ctr;
                     push_rsp(r);
                     chan_ctr++;
                     if (chan_ctr >= chan_v) begin
                        chan_ctr = 0;
                        frame_ctr++;
                     end
                  end
               end
               if (data_left != 0) data_left--;
               if (data_left == 0) begin
                  phase = PH_DONE;
                  push_rsp(make_rsp(wsp_pkg::KIND_FINISH, '0));
               end
            end
            default: ;
         endcase
      end
      if (n_in_step > 0) rsp_queue[rsp_queue.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         rsp_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.result_kind, rsp_mon.sample_bits, rsp_mon.channel_index,
                    rsp_mon.frame_index, rsp_mon.channel_count, rsp_mon.rate_hz,
                    rsp_mon.frame_count, rsp_mon.is_float, rsp_mon.error_code,
                    rsp_mon.last};
            if (rsp_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               if (got !== rsp_queue[0]) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %h actual %h", rsp_queue[0], got);
                  fail_count <= fail_count + 1;
               end
               void'(rsp_queue.pop_front());
            end
         end
         // predict after popping so a same-cycle result sees the older entries
         if (req_mon.valid && req_mon.ready)
            predict_byte(req_mon.data_byte, req_mon.end_of_file);
      end
   end
endmodule

@@ sim/wav_stream_parser_test.sv @@
// Testbench top for the WAV stream parser: byte stimulus, idling and verdict.
`timescale 1ns / 1ps
module wav_stream_parser_test;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count;
   int   n_items;
   int   cycle_ctr;
   int   hold_cycles;
   logic [7:0] file_buf[$];

   wsp_req_if req_bus ();
   wsp_rsp_if rsp_bus ();

   wav_stream_parser uut (.clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));
   wsp_check checker_inst (.clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
                           .fail_count(fail_count), .pending_count(pending_count));

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycle_ctr <= cycle_ctr + 1;
      if (cycle_ctr > 2000000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: random stalls per beat; a long hold-off when requested
   initial begin
      int w;
      rsp_bus.ready <= 0;
      hold_cycles = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (w > 0) begin
            rsp_bus.ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   task automatic put32(logic [31:0] v);
      for (int i = 0; i < 4; i++) file_buf.push_back(v[8*i +: 8]);
   endtask

   task automatic put_tag(logic [31:0] t);
      for (int i = 3; i >= 0; i--) file_buf.push_back(t[8*i +: 8]);
   endtask

   task automatic put_fmt(logic [15:0] code, logic [15:0] ch, logic [31:0] rate,
                          logic [15:0] bits, int extra);
      put_tag(wsp_pkg::TAG_FMT);
      put32(16 + extra);
      file_buf.push_back(code[7:0]); file_buf.push_back(code[15:8]);
      file_buf.push_back(ch[7:0]);   file_buf.push_back(ch[15:8]);
      put32(rate);
      repeat (6) file_buf.push_back(8'($urandom_range(0, 255)));
      file_buf.push_back(bits[7:0]); file_buf.push_back(bits[15:8]);
      repeat (extra) file_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_riff();
      put_tag(wsp_pkg::TAG_RIFF);
      put32($urandom);
      put_tag(wsp_pkg::TAG_WAVE);
   endtask

   // sends the assembled file then an end-of-file beat; "quiet" skips the gaps
   task automatic send_file(bit quiet);
      int w;
      file_buf.push_back(8'h00);
      for (int i = 0; i < file_buf.size(); i++) begin
         w = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
         if (w > 0) begin
            req_bus.valid <= 0;
            repeat (w) @(posedge clock);
         end
         req_bus.valid <= 1;
         req_bus.data_byte <= (i == file_buf.size() - 1) ? 8'($urandom_range(0, 255))
                                                         : file_buf[i];
         req_bus.end_of_file <= (i == file_buf.size() - 1);
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         n_items++;
      end
      req_bus.valid <= 0;
      file_buf.delete();
   endtask

   task automatic wav_file(logic [15:0] code, logic [15:0] ch, logic [15:0] bits,
                           int dlen, bit pre_chunk, int trunc, bit quiet);
      put_riff();
      if (pre_chunk) begin
         put_tag(32'h4C495354);
         put32(3);
         repeat (3) file_buf.push_back(8'($urandom_range(0, 255)));
      end
      put_fmt(code, ch, $urandom, bits, $urandom_range(0, 1) ? 0 : $urandom_range(1, 5));
      put_tag(wsp_pkg::TAG_DATA);
      put32(dlen);
      for (int i = 0; i < dlen; i++) begin
         if (i % 4 == 0 && $urandom_range(0, 5) == 0)
            put32($urandom_range(0, 1) ? 32'h7FC0_0001 : 32'hFF80_0000);
         else
            file_buf.push_back(8'($urandom_range(0, 255)));
      end
      for (int i = 0; i < trunc && file_buf.size() > 0; i++) void'(file_buf.pop_back());
      send_file(quiet);
   endtask

   task automatic wait_drain();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int kind;
      int code;
      req_bus.valid <= 0;
      req_bus.data_byte <= 0;
      req_bus.end_of_file <= 0;
      n_items = 0;
      cycle_ctr = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: header errors, tags, chunk errors, formats, extremes
      send_file(0);                                   // eof at once
      put_tag(wsp_pkg::TAG_RIFF); put32(0); send_file(0);      // short header
      put_tag(32'h52494647); put32(0); put_tag(wsp_pkg::TAG_WAVE); file_buf.push_back(8'h11);
      send_file(0);                                   // bad RIFF then ignored byte
      put_tag(wsp_pkg::TAG_RIFF); put32(0); put_tag(32'h57415646); send_file(0);
      put_riff(); put_tag(wsp_pkg::TAG_FMT); put32(16); repeat (5) file_buf.push_back(8'hFF);
      send_file(0);                                   // short fmt
      put_riff(); put_tag(wsp_pkg::TAG_DATA); put32(4); send_file(0); // data before fmt
      put_riff(); put_tag(32'h4A554E4B); put32(9); send_file(0); // eof in skip
      put_riff(); put_tag(32'h4A554E4B); send_file(0);       // eof in chunk header
      wav_file(1, 1, 16, 0, 0, 0, 0);                 // zero-size data
      wav_file(1, 0, 16, 4, 0, 0, 0);                 // zero channels
      wav_file(3, 2, 16, 4, 0, 0, 0);                 // unsupported combo
      wav_file(2, 1, 16, 4, 0, 0, 0);
      put_riff(); put_fmt(1, 1, 32'hFFFF_FFFF, 16, 0); put_tag(wsp_pkg::TAG_DATA); put32(8);
      file_buf.push_back(8'h00); file_buf.push_back(8'h80);   // -1.0
      file_buf.push_back(8'hFF); file_buf.push_back(8'h7F);   // max
      file_buf.push_back(8'h00); file_buf.push_back(8'h00);
      file_buf.push_back(8'hFF); file_buf.push_back(8'hFF);
      send_file(0);
      wav_file(3, 3, 32, 27, 1, 0, 0);                // partial frame, float
      wav_file(1, 16'hFFFF, 16, 6, 0, 0, 0);          // huge channel count
      wav_file(1, 2, 16, 12, 0, 3, 0);                // short data
      wait_drain();

      // receiver holds off while bytes keep coming
      hold_cycles = 300;
      wav_file(1, 2, 16, 24, 0, 0, 1);
      wait_drain();

      while (n_items < 700) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            code = $urandom_range(0, 1) ? 1 : 3;
            wav_file(16'(code), 16'($urandom_range(1, 3)),
                     (code == 1) ? 16'd16 : 16'd32, $urandom_range(0, 40),
                     1'($urandom_range(0, 1)),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 0, 0);
         end else if (kind == 7)
            wav_file(16'($urandom_range(0, 4)), 16'($urandom_range(0, 2)),
                     $urandom_range(0, 1) ? 16'd16 : 16'd32, $urandom_range(0, 10), 0, 0, 0);
         else begin
            repeat ($urandom_range(0, 30)) file_buf.push_back(8'($urandom_range(0, 255)));
            send_file(0);
         end
         if ($urandom_range(0, 7) == 0) wait_drain();
      end
      wait_drain();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
